// ===== hdl/atsc_pkg.sv =====
// ============================================================================
// atsc_pkg
// Shared types and constants for the allocation trace safety checker.
// ============================================================================
package atsc_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int KEY_BITS    = 32;
    localparam int SIZE_BITS   = 32;
    localparam int CNT_W       = 32;
    localparam int NUM_FIND    = 6;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    // shadow word: {freed, size, key}
    localparam int WORD_W      = 1 + SIZE_BITS + KEY_BITS;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        STS_OK          = 3'd0,
        STS_OVERWRITE   = 3'd1,
        STS_BAD_FREE    = 3'd2,
        STS_REFREE      = 3'd3,
        STS_UNKNOWN     = 3'd4,
        STS_AFTER_FREE  = 3'd5,
        STS_BOUNDS      = 3'd6,
        STS_FULL        = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;   // latch transaction, restart scan
        logic rd;     // issue table read at scan address
        logic exec;   // decide, update table and counters
    } t_dp_cmd;

    typedef struct packed {
        logic addr_last;  // scan address is the last entry
    } t_dp_sts;

endpackage

// ===== hdl/atsc_ram.sv =====
// ============================================================================
// atsc_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module atsc_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/atsc_ctrl.sv =====
// ============================================================================
// atsc_ctrl
// Sequencer: accept, scan the shadow table, drain the read pipe, execute.
// ============================================================================
module atsc_ctrl
    import atsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EXEC;  // last entry compared this cycle
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== hdl/atsc_dp.sv =====
// ============================================================================
// atsc_dp
// Datapath: shadow table, key scan, decision logic and finding counters.
// ============================================================================
module atsc_dp
    import atsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_sts           o_sts,
    input  logic [1:0]        i_op,
    input  logic [31:0]       i_pointer_key,
    input  logic [31:0]       i_amount,
    input  logic [31:0]       i_access_length,
    output logic              o_valid,
    output logic [2:0]        o_status,
    output logic [CNT_W-1:0]  o_cnt [NUM_FIND],
    output logic [CNT_W-1:0]  o_leak_count
);

    // transaction latch
    t_op                  r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [SIZE_BITS-1:0] r_amt;
    logic [SIZE_BITS-1:0] r_len;

    // scan pipe
    logic [IDX_W-1:0]     r_addr;
    logic                 r_cmp_vld;
    logic [IDX_W-1:0]     r_cmp_idx;
    logic [WORD_W-1:0]    w_rdata;
    logic [KEY_BITS-1:0]  w_rkey;
    logic [SIZE_BITS-1:0] w_rsize;
    logic                 w_rfreed;
    logic                 w_match;

    // scan results
    logic                 r_hit_found;
    logic [IDX_W-1:0]     r_hit_idx;
    logic                 r_hit_freed;
    logic [SIZE_BITS-1:0] r_hit_size;
    logic                 r_emp_found;
    logic [IDX_W-1:0]     r_emp_idx;

    // table valid bits and counters
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]       r_cnt [NUM_FIND];
    logic [CNT_W-1:0]       r_leak;
    logic                   r_out_vld;
    t_status                r_status;

    // execute decisions
    t_status              n_status;
    logic                 n_flag;
    logic                 n_we;
    logic [IDX_W-1:0]     n_waddr;
    logic [WORD_W-1:0]    n_wdata;
    logic                 n_leak_inc;
    logic                 n_leak_dec;

    atsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_rkey   = w_rdata[KEY_BITS-1:0];
    assign w_rsize  = w_rdata[KEY_BITS +: SIZE_BITS];
    assign w_rfreed = w_rdata[WORD_W-1];
    assign w_match  = r_cmp_vld && r_valid[r_cmp_idx] && (w_rkey == r_key);

    assign o_sts.addr_last = (r_addr == IDX_W'(TABLE_DEPTH - 1));

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= t_op'(i_op);
            r_key <= i_pointer_key[KEY_BITS-1:0];
            r_amt <= i_amount[SIZE_BITS-1:0];
            r_len <= i_access_length[SIZE_BITS-1:0];
        end
        r_cmp_idx <= r_addr;
        if (w_match && !r_hit_found) begin
            r_hit_idx   <= r_cmp_idx;
            r_hit_freed <= w_rfreed;
            r_hit_size  <= w_rsize;
        end
        if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_emp_found) begin
            r_emp_idx <= r_cmp_idx;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit_found <= 1'b0;
            r_emp_found <= 1'b0;
            r_valid     <= '0;
            r_leak      <= '0;
            r_out_vld   <= 1'b0;
            for (int i = 0; i < NUM_FIND; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            r_cmp_vld <= i_cmd.rd;
            r_out_vld <= i_cmd.exec;
            if (i_cmd.load) begin
                r_addr      <= '0;
                r_hit_found <= 1'b0;
                r_emp_found <= 1'b0;
            end else begin
                if (i_cmd.rd) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (w_match) begin
                    r_hit_found <= 1'b1;
                end
                if (r_cmp_vld && !r_valid[r_cmp_idx]) begin
                    r_emp_found <= 1'b1;
                end
            end
            if (n_we) begin
                r_valid[n_waddr] <= 1'b1;
            end
            if (n_leak_inc && (r_leak != '1)) begin
                r_leak <= r_leak + 1'b1;
            end else if (n_leak_dec && (r_leak != '0)) begin
                r_leak <= r_leak - 1'b1;
            end
            for (int i = 0; i < NUM_FIND; i++) begin
                if (n_flag && (n_status == t_status'(3'(i + 1))) && (r_cnt[i] != '1)) begin
                    r_cnt[i] <= r_cnt[i] + 1'b1;
                end
            end
        end
    end

    // decision for the latched transaction
    always_comb begin
        n_status   = STS_OK;
        n_flag     = 1'b0;
        n_we       = 1'b0;
        n_waddr    = r_hit_idx;
        n_wdata    = {1'b0, r_amt, r_key};
        n_leak_inc = 1'b0;
        n_leak_dec = 1'b0;
        if (i_cmd.exec) begin
            case (r_op)
                OP_ALLOC: begin
                    if (!r_hit_found && !r_emp_found) begin
                        n_status = STS_FULL;
                    end else begin
                        if (r_hit_found && !r_hit_freed) begin
                            n_status = STS_OVERWRITE;
                            n_flag   = 1'b1;
                        end
                        n_we       = 1'b1;
                        n_waddr    = r_hit_found ? r_hit_idx : r_emp_idx;
                        n_leak_inc = 1'b1;
                    end
                end
                OP_FREE: begin
                    if (!r_hit_found) begin
                        n_status = STS_BAD_FREE;
                        n_flag   = 1'b1;
                    end else if (r_hit_freed) begin
                        n_status = STS_REFREE;
                        n_flag   = 1'b1;
                    end else begin
                        n_we       = 1'b1;
                        n_wdata    = {1'b1, r_hit_size, r_key};
                        n_leak_dec = 1'b1;
                    end
                end
                default: begin
                    // read or write access
                    if (!r_hit_found) begin
                        n_status = STS_UNKNOWN;
                        n_flag   = 1'b1;
                    end else if (r_hit_freed) begin
                        n_status = STS_AFTER_FREE;
                        n_flag   = 1'b1;
                    end else if ((r_amt > r_hit_size) || (r_len > (r_hit_size - r_amt))) begin
                        n_status = STS_BOUNDS;
                        n_flag   = 1'b1;
                    end
                end
            endcase
        end
    end

    assign o_valid      = r_out_vld;
    assign o_status     = r_status;
    assign o_cnt        = r_cnt;
    assign o_leak_count = r_leak;

endmodule

// ===== hdl/alloc_trace_safety_checker.sv =====
// ============================================================================
// alloc_trace_safety_checker
// Checks alloc/free/read/write transactions against a keyed shadow table.
// ============================================================================
// Sequence: after the accepting edge the block scans all TABLE_DEPTH table
//   entries, drains the read pipe and executes; o_valid is registered from execute.
// A new transaction is taken only once busy is low; the key scan reads
//   one table entry per cycle through the shadow RAM's single read port.
// busy is low in the result cycle, so the next start can be taken there.
// Reset (i_rst_n, synchronous): valid bits, counters and FSM cleared; the
//   shadow RAM itself is not cleared. The receiver cannot stall results.
module alloc_trace_safety_checker
    import atsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_pointer_key,
    input  logic [31:0] i_amount,
    input  logic [31:0] i_access_length,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_overwritten_count,
    output logic [31:0] o_bad_free_count,
    output logic [31:0] o_refree_count,
    output logic [31:0] o_unknown_access_count,
    output logic [31:0] o_after_free_count,
    output logic [31:0] o_bounds_count,
    output logic [31:0] o_leak_count
);

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic [CNT_W-1:0] w_cnt [NUM_FIND];

    // controller: sequences accept -> scan -> drain -> execute
    atsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd),
        .i_sts   (w_sts)
    );

    // datapath: shadow table RAM, compare pipe, counters
    atsc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_op            (i_op),
        .i_pointer_key   (i_pointer_key),
        .i_amount        (i_amount),
        .i_access_length (i_access_length),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_cnt           (w_cnt),
        .o_leak_count    (o_leak_count)
    );

    // counter order follows the finding codes
    assign o_overwritten_count    = w_cnt[0];
    assign o_bad_free_count       = w_cnt[1];
    assign o_refree_count         = w_cnt[2];
    assign o_unknown_access_count = w_cnt[3];
    assign o_after_free_count     = w_cnt[4];
    assign o_bounds_count         = w_cnt[5];

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // a taken transaction keeps the block busy while it scans
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    // a result strobe is a single-cycle pulse
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // result shows up only after the transaction has finished
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // a dropped alloc leaves the live count alone
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == STS_FULL) && $past(i_rst_n)) |-> $stable(o_leak_count))
        else $error("live count changed on table-full alloc");

endmodule
